FILE: design/best_fit_heap_allocator_unit_assert.svh
// Assertion macros for the allocator's checker file.
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BFHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define BFHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

FILE: design/bfha_pkg.sv
// Types, codes and helpers shared by the allocator modules.
package bfha_pkg;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] cap;
    logic [15:0] used;
    logic        isfree;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] size;
    logic [15:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pa;
    logic [15:0] gs;
    logic [15:0] cb;
    logic [6:0]  total;
    logic [6:0]  nfree;
    logic [15:0] used;
    logic [15:0] fbytes;
    logic [15:0] waste;
  } res_t;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [7:0]  HEADER_RESET = 8'd40;
  localparam logic [16:0] LIMIT_RESET  = 17'h10000;
  localparam logic [17:0] SPLIT_MIN    = 18'd4;

  function automatic logic [15:0] sat16(input logic [17:0] v);
    sat16 = (v > 18'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

FILE: design/bfha_table.sv
// Block table memory: one write port, one registered read port.
module bfha_table #(
  parameter int DEPTH = 64,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  bfha_pkg::entry_t  wdata,
  input  logic [IW-1:0]     raddr,
  output bfha_pkg::entry_t  rdata
);
  import bfha_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bfha_seq.sv
// Request sequencer: scans, shifts and updates the block table one entry a cycle.
module bfha_seq #(
  parameter int MAX_BLOCKS = 64,
  parameter int HEAP_BYTES = 65536,
  parameter int ALIGN_BYTES = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bfha_pkg::req_t  req,
  input  logic [7:0]      hdr,
  input  logic [16:0]     lim,
  output logic            idle,
  output logic            res_valid,
  input  logic            res_ack,
  output bfha_pkg::res_t  res
);
  import bfha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [16:0] ALIGN17 = 17'(ALIGN_BYTES);
  localparam logic [16:0] ALIGN_MASK = ALIGN17 - 17'd1;
  localparam logic [16:0] HEAP_CAP = (HEAP_BYTES > 65535) ? 17'h0FFFF : 17'(HEAP_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_ACHK = 5'd3;
  localparam logic [4:0] S_BEST = 5'd4;
  localparam logic [4:0] S_BDONE = 5'd5;
  localparam logic [4:0] S_SHUP = 5'd6;
  localparam logic [4:0] S_WNEW = 5'd7;
  localparam logic [4:0] S_WBEST = 5'd8;
  localparam logic [4:0] S_GROW = 5'd9;
  localparam logic [4:0] S_AEND = 5'd10;
  localparam logic [4:0] S_FIND = 5'd11;
  localparam logic [4:0] S_FRES = 5'd12;
  localparam logic [4:0] S_REL0 = 5'd13;
  localparam logic [4:0] S_REL1 = 5'd14;
  localparam logic [4:0] S_REL2 = 5'd15;
  localparam logic [4:0] S_REL3 = 5'd16;
  localparam logic [4:0] S_RMV = 5'd17;
  localparam logic [4:0] S_SST = 5'd18;
  localparam logic [4:0] S_STAT = 5'd19;
  localparam logic [4:0] S_DONE = 5'd20;

  localparam logic [1:0] P_FREE = 2'd0;
  localparam logic [1:0] P_REAL = 2'd1;
  localparam logic [1:0] P_MOVE = 2'd2;

  logic [4:0]    state;
  logic [1:0]    op;
  logic [15:0]   size;
  logic [15:0]   addr;
  logic [16:0]   s;
  logic [CW-1:0] cnt;
  logic [16:0]   brk;
  logic [CW-1:0] ri;
  logic          pv;
  logic [IW-1:0] pi;
  logic          found;
  logic          split;
  logic [IW-1:0] best;
  logic [15:0]   bestcap;
  logic [15:0]   beststart;
  logic [IW-1:0] kidx;
  entry_t        kent;
  logic [1:0]    purp;
  logic          moving;
  logic          rel_down;
  logic [15:0]   old_used;
  logic [1:0]    status;
  logic [15:0]   pa;
  logic [15:0]   gs;
  logic [15:0]   cb;
  logic [15:0]   curcap;
  logic [CW-1:0] rmr;
  logic [CW-1:0] shn;
  logic [CW-1:0] acc_nf;
  logic [15:0]   acc_used;
  logic [15:0]   acc_fb;
  logic [15:0]   acc_waste;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rdata;

  logic          fin;
  logic          hit;
  logic [16:0]   limnow;
  logic [18:0]   grow_end;
  logic          grow_ok;
  logic          fits;

  bfha_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign fin = (cnt == '0) || (pv && (CW'(pi) == cnt - ONE));
  assign hit = pv && (rdata.start == addr) && !rdata.isfree;
  assign limnow = (lim > HEAP_CAP) ? HEAP_CAP : lim;
  assign grow_end = 19'(brk) + 19'(hdr) + 19'(s);
  assign grow_ok = (cnt < MAXC) && (grow_end <= 19'(limnow));
  assign fits = rdata.isfree && (17'(rdata.cap) >= s) && (!found || rdata.cap < bestcap);

  always_comb begin
    we = 1'b0;
    waddr = best;
    wdata = rdata;
    raddr = ri[IW-1:0];
    unique case (state)
      S_SHUP: begin
        we = pv;
        waddr = pi + IW'(1);
      end
      S_RMV: begin
        we = pv;
        waddr = pi - IW'(1);
      end
      S_WNEW: begin
        we = 1'b1;
        waddr = best + IW'(1);
        wdata.start = beststart + s[15:0] + 16'(hdr);
        wdata.cap = bestcap - s[15:0] - 16'(hdr);
        wdata.used = '0;
        wdata.isfree = 1'b1;
      end
      S_WBEST: begin
        we = 1'b1;
        waddr = best;
        wdata.start = beststart;
        wdata.cap = split ? s[15:0] : bestcap;
        wdata.used = s[15:0];
        wdata.isfree = 1'b0;
      end
      S_GROW: begin
        we = grow_ok;
        waddr = cnt[IW-1:0];
        wdata.start = brk[15:0] + 16'(hdr);
        wdata.cap = s[15:0];
        wdata.used = s[15:0];
        wdata.isfree = 1'b0;
      end
      S_REL0: begin
        raddr = kidx + IW'(1);
      end
      S_REL2: begin
        we = 1'b1;
        waddr = kidx;
        wdata.start = kent.start;
        wdata.cap = curcap;
        wdata.used = '0;
        wdata.isfree = 1'b1;
        raddr = kidx - IW'(1);
      end
      S_REL3: begin
        we = rdata.isfree;
        waddr = kidx - IW'(1);
        wdata.cap = sat16(18'(rdata.cap) + 18'(hdr) + 18'(curcap));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      brk <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= req.op;
            size <= req.size;
            addr <= req.addr;
            moving <= 1'b0;
            status <= ST_OK;
            pa <= '0;
            gs <= '0;
            cb <= '0;
            state <= S_DISP;
          end
        end
        // round the size up to the alignment (a power of two)
        S_DISP: begin
          s <= ({1'b0, size} + ALIGN_MASK) & ~ALIGN_MASK;
          ri <= '0;
          pv <= 1'b0;
          unique case (op)
            OP_ALLOC: state <= S_ACHK;
            OP_FREE: begin
              purp <= P_FREE;
              state <= (addr == '0) ? S_SST : S_FIND;
            end
            OP_REALLOC: begin
              purp <= P_REAL;
              state <= (addr == '0) ? S_ACHK : S_FIND;
            end
            default: state <= S_SST;
          endcase
        end
        S_ACHK: begin
          ri <= '0;
          pv <= 1'b0;
          found <= 1'b0;
          if (s == '0 || s[16]) begin
            status <= ST_NOSPACE;
            state <= S_AEND;
          end else begin
            state <= S_BEST;
          end
        end
        S_BEST: begin
          pv <= ri < cnt;
          pi <= ri[IW-1:0];
          if (ri < cnt) ri <= ri + ONE;
          if (pv && fits) begin
            found <= 1'b1;
            best <= pi;
            bestcap <= rdata.cap;
            beststart <= rdata.start;
          end
          if (fin) state <= S_BDONE;
        end
        S_BDONE: begin
          if (found) begin
            split <= (18'(bestcap) >= 18'(s) + 18'(hdr) + SPLIT_MIN) && (cnt < MAXC);
            pa <= beststart;
            shn <= CW'(best) + ONE;
            ri <= cnt - ONE;
            pv <= 1'b0;
            if ((18'(bestcap) >= 18'(s) + 18'(hdr) + SPLIT_MIN) && (cnt < MAXC)) begin
              gs <= s[15:0];
              state <= (cnt > CW'(best) + ONE) ? S_SHUP : S_WNEW;
            end else begin
              gs <= bestcap;
              state <= S_WBEST;
            end
          end else begin
            state <= S_GROW;
          end
        end
        // open a slot above the chosen block, top entry first
        S_SHUP: begin
          pv <= ri >= shn;
          pi <= ri[IW-1:0];
          ri <= ri - ONE;
          if (pv && CW'(pi) == shn) state <= S_WNEW;
        end
        S_WNEW: begin
          cnt <= cnt + ONE;
          state <= S_WBEST;
        end
        S_WBEST: begin
          status <= ST_OK;
          state <= S_AEND;
        end
        S_GROW: begin
          if (cnt >= MAXC) begin
            status <= ST_FULL;
          end else if (!grow_ok) begin
            status <= ST_NOSPACE;
          end else begin
            cnt <= cnt + ONE;
            brk <= grow_end[16:0];
            pa <= brk[15:0] + 16'(hdr);
            gs <= s[15:0];
          end
          state <= S_AEND;
        end
        S_AEND: begin
          ri <= '0;
          pv <= 1'b0;
          if (moving && status == ST_OK) begin
            cb <= old_used;
            purp <= P_MOVE;
            state <= S_FIND;
          end else begin
            state <= S_SST;
          end
        end
        S_FIND: begin
          pv <= ri < cnt;
          pi <= ri[IW-1:0];
          if (ri < cnt) ri <= ri + ONE;
          if (hit) begin
            found <= 1'b1;
            kidx <= pi;
            kent <= rdata;
            state <= S_FRES;
          end else if (fin) begin
            found <= 1'b0;
            state <= S_FRES;
          end
        end
        S_FRES: begin
          unique case (purp)
            P_FREE: begin
              if (found) begin
                state <= S_REL0;
              end else begin
                status <= ST_BADADDR;
                state <= S_SST;
              end
            end
            P_REAL: begin
              if (!found) begin
                status <= ST_BADADDR;
                state <= S_SST;
              end else if (kent.cap >= size) begin
                pa <= addr;
                gs <= kent.cap;
                state <= S_SST;
              end else begin
                old_used <= kent.used;
                moving <= 1'b1;
                state <= S_ACHK;
              end
            end
            default: state <= found ? S_REL0 : S_SST;
          endcase
        end
        S_REL0: begin
          curcap <= kent.cap;
          state <= (CW'(kidx) + ONE < cnt) ? S_REL1 : S_REL2;
        end
        // merge with the next block when it is free
        S_REL1: begin
          if (rdata.isfree) begin
            curcap <= sat16(18'(curcap) + 18'(hdr) + 18'(rdata.cap));
            rmr <= CW'(kidx) + ONE;
            ri <= CW'(kidx) + ONE + ONE;
            pv <= 1'b0;
            rel_down <= 1'b0;
            state <= S_RMV;
          end else begin
            state <= S_REL2;
          end
        end
        S_REL2: begin
          state <= (kidx != '0) ? S_REL3 : S_SST;
        end
        // merge into the previous block when it is free
        S_REL3: begin
          if (rdata.isfree) begin
            rmr <= CW'(kidx);
            ri <= CW'(kidx) + ONE;
            pv <= 1'b0;
            rel_down <= 1'b1;
            state <= S_RMV;
          end else begin
            state <= S_SST;
          end
        end
        // close the gap at rmr, lowest entry first
        S_RMV: begin
          pv <= ri < cnt;
          pi <= ri[IW-1:0];
          if (ri < cnt) ri <= ri + ONE;
          if ((rmr + ONE >= cnt) || (pv && CW'(pi) == cnt - ONE)) begin
            cnt <= cnt - ONE;
            state <= rel_down ? S_SST : S_REL2;
          end
        end
        S_SST: begin
          ri <= '0;
          pv <= 1'b0;
          acc_nf <= '0;
          acc_used <= '0;
          acc_fb <= '0;
          acc_waste <= '0;
          state <= S_STAT;
        end
        S_STAT: begin
          pv <= ri < cnt;
          pi <= ri[IW-1:0];
          if (ri < cnt) ri <= ri + ONE;
          if (pv) begin
            if (rdata.isfree) begin
              acc_nf <= acc_nf + ONE;
              acc_fb <= acc_fb + rdata.cap;
            end else begin
              acc_used <= acc_used + rdata.used;
              acc_waste <= acc_waste + rdata.cap - rdata.used;
            end
          end
          if (fin) state <= S_DONE;
        end
        S_DONE: begin
          if (res_ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status = status;
    res.pa = (status == ST_OK) ? pa : '0;
    res.gs = (status == ST_OK) ? gs : '0;
    res.cb = (status == ST_OK) ? cb : '0;
    res.total = 7'(cnt);
    res.nfree = 7'(acc_nf);
    res.used = acc_used;
    res.fbytes = acc_fb;
    res.waste = acc_waste;
  end

endmodule

FILE: design/best_fit_heap_allocator_unit.sv
// Best-fit heap allocator: one request in, one result with statistics out.
// Each request runs through control states and passes over the block table
// (N = current block count), each moving one entry per cycle through the
// table's one read port: a best-fit or address scan, a shift of up to N-1
// entries when a block is split or removed by a merge, and a statistics
// scan. A moving reallocate whose free merges on both sides is the longest.
// ALIGN_BYTES must be a power of two. The block takes no new request
// until the result has entered the output register; the result then waits
// there while the next request runs.
module best_fit_heap_allocator_unit #(
  parameter int MAX_BLOCKS = 64,
  parameter int HEAP_BYTES = 65536,
  parameter int ALIGN_BYTES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // request_size[15:0], address[31:16]
  input  logic [1:0]    s_tuser,   // opcode[1:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // status, payload_address, granted_size, copy_bytes,
                                   // total_blocks, free_blocks, used_bytes,
                                   // free_bytes, wasted_bytes
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bfha_pkg::*;

  logic [7:0]  hdr;
  logic [16:0] lim;
  req_t        req;
  res_t        res;
  res_t        out_reg;
  logic        idle;
  logic        res_valid;
  logic        res_ack;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= HEADER_RESET;
      lim <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_HEADER: hdr <= pwdata[7:0];
        REG_LIMIT:  lim <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? {15'd0, lim} : {24'd0, hdr};

  assign req.op = s_tuser;
  assign req.size = s_tdata[15:0];
  assign req.addr = s_tdata[31:16];
  assign s_tready = idle;

  bfha_seq #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .HEAP_BYTES(HEAP_BYTES),
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (s_tvalid && s_tready),
    .req      (req),
    .hdr      (hdr),
    .lim      (lim),
    .idle     (idle),
    .res_valid(res_valid),
    .res_ack  (res_ack),
    .res      (res)
  );

  assign res_ack = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ack) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {out_reg.waste, out_reg.fbytes, out_reg.used, out_reg.nfree,
                    out_reg.total, out_reg.cb, out_reg.gs, out_reg.pa, out_reg.status};

endmodule

FILE: design/bfha_checker.sv
// Port-level checks for the allocator, bound to the top level.
`include "best_fit_heap_allocator_unit_assert.svh"

module bfha_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [111:0]  m_tdata
);
  import bfha_pkg::*;

  // a stalled result holds
  `BFHA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // one request at a time
  `BFHA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  // a failed request grants nothing
  `BFHA_ASSERT_IMPL(a_fail_zero, clk, rst, m_tvalid && (m_tdata[1:0] != ST_OK), m_tdata[49:2] == 48'd0)
  // free blocks never outnumber all blocks
  `BFHA_ASSERT_IMPL(a_free_le_total, clk, rst, m_tvalid, m_tdata[63:57] <= m_tdata[56:50])

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (.*);
